@@ rtl/dwm_pkg.sv @@
package dwm_pkg;

  localparam int NEEDLE_WORDS = 6;
  localparam int NEEDLE_BYTES = 8 * NEEDLE_WORDS;
  localparam int SEEN_W       = 6;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  localparam logic [SEEN_W-1:0] SEEN_CAP  = '1;
  localparam logic [7:0]        SEMICOLON = 8'h3B;

  typedef enum logic [2:0] {
    REG_WORD0 = 3'd0,
    REG_WORD1 = 3'd1,
    REG_WORD2 = 3'd2,
    REG_WORD3 = 3'd3,
    REG_WORD4 = 3'd4,
    REG_WORD5 = 3'd5,
    REG_LEN   = 3'd6,
    REG_MODE  = 3'd7
  } reg_idx_t;

  typedef enum logic {
    MODE_SEMICOLON = 1'b0,
    MODE_ALNUM     = 1'b1
  } delim_mode_t;

  typedef struct packed {
    logic [NEEDLE_BYTES-1:0][7:0] needle;
    logic [SEEN_W-1:0]            len;
    delim_mode_t                  mode;
  } cfg_t;

  function automatic logic is_delim(logic [7:0] c, delim_mode_t mode);
    logic alnum;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
    if (mode == MODE_SEMICOLON) begin
      return c == SEMICOLON;
    end
    return !alnum;
  endfunction

endpackage

@@ rtl/dwm_if.sv @@
interface dwm_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_char;
  logic       char_valid;
  logic       last;

  modport source (output valid, header_char, char_valid, last, input ready);
  modport sink   (input valid, header_char, char_valid, last, output ready);
endinterface

interface dwm_res_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

@@ rtl/dwm_cell.sv @@
module dwm_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] char_in,
  input  logic [7:0] ndl_char,
  input  logic       active,
  output logic [7:0] char_q,
  output logic [7:0] char_next,
  output logic       eq_now,
  output logic       eq_next
);

  // char_next is the window byte once the current beat has shifted in
  assign char_next = shift ? char_in : char_q;
  assign eq_now    = !active || (char_q == ndl_char);
  assign eq_next   = !active || (char_next == ndl_char);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      char_q <= '0;
    end else if (shift) begin
      char_q <= char_in;
    end
  end

endmodule

@@ rtl/dwm_regs.sv @@
module dwm_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dwm_pkg::ADDR_W-1:0] paddr,
  input  logic [dwm_pkg::DATA_W-1:0] pwdata,
  output logic [dwm_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output dwm_pkg::cfg_t             cfg
);

  logic [dwm_pkg::NEEDLE_WORDS-1:0][dwm_pkg::DATA_W-1:0] words;
  logic [dwm_pkg::SEEN_W-1:0] len;
  dwm_pkg::delim_mode_t       mode;
  dwm_pkg::reg_idx_t          idx;
  logic                       wr;

  assign idx    = dwm_pkg::reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  assign cfg.needle = words;
  assign cfg.len    = len;
  assign cfg.mode   = mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
      len   <= '0;
      mode  <= dwm_pkg::MODE_SEMICOLON;
    end else if (wr) begin
      unique case (idx) inside
        dwm_pkg::REG_WORD0, dwm_pkg::REG_WORD1, dwm_pkg::REG_WORD2,
        dwm_pkg::REG_WORD3, dwm_pkg::REG_WORD4, dwm_pkg::REG_WORD5: begin
          words[idx] <= pwdata;
        end
        dwm_pkg::REG_LEN: begin
          len <= pwdata[dwm_pkg::SEEN_W-1:0];
        end
        dwm_pkg::REG_MODE: begin
          mode <= dwm_pkg::delim_mode_t'(pwdata[0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx) inside
      dwm_pkg::REG_WORD0, dwm_pkg::REG_WORD1, dwm_pkg::REG_WORD2,
      dwm_pkg::REG_WORD3, dwm_pkg::REG_WORD4, dwm_pkg::REG_WORD5: begin
        prdata = words[idx];
      end
      dwm_pkg::REG_LEN: begin
        prdata = dwm_pkg::DATA_W'(len);
      end
      dwm_pkg::REG_MODE: begin
        prdata = dwm_pkg::DATA_W'(mode);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/delimited_word_matcher.sv @@
// Channel  Dir  Handshake      Payload
// hdr      in   valid/ready    header_char[7:0], char_valid, last
// res      out  valid/ready    matched
// apb      in   psel/penable   paddr[5:0], pwdata[63:0] -> prdata[63:0]
//
// One header beat per cycle; the verdict is set by one pass through the row of
// window cells and reaches res the cycle after the beat with last, or later
// when an older verdict still waits at the head of the queue.
// Synchronous reset clears the window, position count, verdict and queue.
// A two-entry result queue keeps hdr open while one verdict waits on res;
// hdr stalls only when both entries are full.
module delimited_word_matcher #(
  parameter int NEEDLE_MAX = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  dwm_hdr_if.sink                    hdr,
  dwm_res_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dwm_pkg::ADDR_W-1:0] paddr,
  input  logic [dwm_pkg::DATA_W-1:0] pwdata,
  output logic [dwm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int LW = $clog2(NEEDLE_MAX + 1);
  localparam int SW = dwm_pkg::SEEN_W;
  localparam int NW = $clog2(dwm_pkg::NEEDLE_BYTES);

  dwm_pkg::cfg_t cfg;

  logic [NEEDLE_MAX:0][7:0] win;
  logic [NEEDLE_MAX:0][7:0] win_next;
  logic [NEEDLE_MAX:0][7:0] ndl_at;
  logic [NEEDLE_MAX:0]      active;
  logic [NEEDLE_MAX:0]      eq_now;
  logic [NEEDLE_MAX:0]      eq_next;

  logic [LW-1:0] len_eff;
  logic [SW-1:0] len6;
  logic [SW-1:0] seen;
  logic [SW-1:0] seen_next;
  logic          hit;
  logic          hit_next;
  logic          accept;
  logic          shift;
  logic          fin;
  logic          ends_now;
  logic          ends_next;
  logic          verdict;

  logic [1:0] q_cnt;
  logic       q0;
  logic       q1;
  logic       push;
  logic       pop;

  dwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign len_eff = (cfg.len > SW'(NEEDLE_MAX)) ? LW'(NEEDLE_MAX) : LW'(cfg.len);
  assign len6    = SW'(len_eff);

  // align the needle so that cell i compares against needle[len-1-i]
  always_comb begin
    for (int i = 0; i <= NEEDLE_MAX; i++) begin
      active[i] = (SW'(i) < len6);
      ndl_at[i] = '0;
      if (active[i]) begin
        ndl_at[i] = cfg.needle[NW'(len6 - SW'(i) - SW'(1))];
      end
    end
  end

  assign accept = hdr.valid && hdr.ready;
  assign shift  = accept && hdr.char_valid;
  assign fin    = accept && hdr.last;

  for (genvar i = 0; i <= NEEDLE_MAX; i++) begin : g_cell
    dwm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .clear     (fin),
      .char_in   ((i == 0) ? hdr.header_char : win[(i == 0) ? 0 : i - 1]),
      .ndl_char  (ndl_at[i]),
      .active    (active[i]),
      .char_q    (win[i]),
      .char_next (win_next[i]),
      .eq_now    (eq_now[i]),
      .eq_next   (eq_next[i])
    );
  end

  assign seen_next = shift ? (seen + SW'(seen != dwm_pkg::SEEN_CAP)) : seen;

  assign ends_now  = (&eq_now) && (seen >= len6) &&
                     ((seen == len6) || dwm_pkg::is_delim(win[len_eff], cfg.mode));
  assign ends_next = (&eq_next) && (seen_next >= len6) &&
                     ((seen_next == len6) ||
                      dwm_pkg::is_delim(win_next[len_eff], cfg.mode));

  // a delimiter closes any word that ends just before it
  assign hit_next = hit ||
                    (shift && dwm_pkg::is_delim(hdr.header_char, cfg.mode) && ends_now);
  assign verdict  = hit_next || ends_next;

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      seen <= '0;
      hit  <= 1'b0;
    end else begin
      seen <= seen_next;
      hit  <= hit_next;
    end
  end

  // two-entry result queue, head in q0
  assign push      = fin;
  assign pop       = res.valid && res.ready;
  assign hdr.ready = (q_cnt != 2'd2);
  assign res.valid = (q_cnt != 2'd0);
  assign res.matched = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (push && q_cnt == 2'd1) ? verdict : q1;
      if (push && q_cnt == 2'd2) begin
        q1 <= verdict;
      end
    end else if (push) begin
      if (q_cnt == 2'd0) begin
        q0 <= verdict;
      end else begin
        q1 <= verdict;
      end
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_cnt != 2'd2))
    else $error("verdict pushed into full queue");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fin |=> (seen == '0) && !hit)
    else $error("header state not cleared after last beat");

  a_hit_needs_char: assert property (@(posedge clk) disable iff (rst)
    $rose(hit) |-> $past(shift))
    else $error("hit flag set without a character beat");

  a_res_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> res.valid)
    else $error("verdict lost from queue");

endmodule
